/* sv/crle_pkg.sv */
`default_nettype none
package crle_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ShiftWidth = 7;

  localparam logic [ShiftWidth-1:0] VarintStep  = ShiftWidth'(7);
  localparam logic [ShiftWidth-1:0] VarintLimit = ShiftWidth'(64);
  localparam logic [ShiftWidth-1:0] ShiftMax    = ShiftWidth'(70);
  localparam logic [ByteWidth-1:0]  RunBias     = ByteWidth'(3);
  localparam logic [ByteWidth-1:0]  MaskFirst   = 8'h80;
  localparam logic [ByteWidth-1:0]  DataBits    = 8'h7F;

  typedef enum logic [1:0] {
    KIND_BOOL = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_UINT = 2'd2,
    KIND_SINT = 2'd3
  } kind_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_DELTA  = 3'd1,
    PH_BASE   = 3'd2,
    PH_LIT    = 3'd3,
    PH_READY  = 3'd4
  } phase_t;

endpackage
`default_nettype wire

/* sv/columnar_rle_v1_stream_decoder.sv */
// Run-length (v1) column stream decoder.
// Input channel: in_tdata carries one stream byte, in_tuser the operation
// (0 push a stream byte, 1 pull the next decoded value).
// Output channel: one transfer for every pull and for every byte that arrives
// while a value is still pending; pushed bytes that are taken give none.
// out_tdata is the 64-bit value, out_tuser the status (0 valid, 1 nothing
// pending, 2 byte refused), out_tlast marks the final value of a run or group.
// cfg_wr_en/cfg_wr_data set the element kind (0 bool, 1 byte, 2 unsigned,
// 3 signed zigzag) and drop any group in progress; write only while idle.
// Pipeline: an input transfer is captured in the input register, decoded
// combinationally from it, and its result is captured in the output register.
// Throughput: one input transfer per cycle unless stalled as below; the decode
// state update (one 64-bit add for run deltas) is the only stage between the two registers.
// A stalled receiver holds the output register; the input register keeps
// accepting bytes that produce no result and only stalls items that need
// the occupied output slot.
// Reset (rst_n low, synchronous): kind returns to unsigned, parser expects
// a header byte and both registers empty.
`default_nettype none
module columnar_rle_v1_stream_decoder
  import crle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast   // group_last
);

  kind_t                  kind_r;
  phase_t                 phase_r, phase_nxt;
  logic                   is_run_r, is_run_nxt;
  logic [ByteWidth-1:0]   items_left_r, items_left_nxt;
  logic [ValueWidth-1:0]  cur_r, cur_nxt;
  logic [ByteWidth-1:0]   delta_r, delta_nxt;
  logic [ShiftWidth-1:0]  shift_r, shift_nxt;
  logic [ByteWidth-1:0]   bit_mask_r, bit_mask_nxt;
  logic [ByteWidth-1:0]   bits_byte_r, bits_byte_nxt;

  logic                   in_v_r;
  op_t                    in_op_r;
  logic [ByteWidth-1:0]   in_byte_r;

  logic                   out_v_r;
  logic [ValueWidth-1:0]  out_value_r, out_value_nxt;
  status_t                out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   has_result, fire;
  logic                   varint_done, group_end, bool_elem_end;
  logic [ByteWidth-1:0]   items_dec, mask_shifted;
  logic [ValueWidth-1:0]  delta_ext, zz_plain, zz_sum, varint_bits;

  assign has_result    = (in_op_r == OP_PULL) || (phase_r == PH_READY);
  assign fire          = in_v_r && (!has_result || !out_v_r || out_tready);
  assign in_tready     = !in_v_r || fire;

  assign varint_done   = !in_byte_r[ByteWidth-1];
  assign items_dec     = items_left_r - 8'd1;
  assign group_end     = (items_dec == '0);
  assign mask_shifted  = bit_mask_r >> 1;
  assign bool_elem_end = (mask_shifted == '0);
  assign delta_ext     = {{(ValueWidth-ByteWidth){delta_r[ByteWidth-1]}}, delta_r};
  assign zz_plain      = (cur_r >> 1) ^ {ValueWidth{cur_r[0]}};
  assign zz_sum        = zz_plain + delta_ext;
  assign varint_bits   = ValueWidth'(in_byte_r & DataBits) << shift_r;

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_op_r == OP_BYTE) begin
      unique case (phase_r)
        PH_DELTA: phase_nxt = PH_BASE;
        PH_BASE, PH_LIT: begin
          if (kind_r == KIND_BOOL || kind_r == KIND_BYTE || varint_done) begin
            phase_nxt = PH_READY;
          end
        end
        PH_READY: phase_nxt = PH_READY;
        default: begin
          if (in_byte_r[ByteWidth-1]) begin
            phase_nxt = PH_LIT;
          end else if (kind_r == KIND_UINT || kind_r == KIND_SINT) begin
            phase_nxt = PH_DELTA;
          end else begin
            phase_nxt = PH_BASE;
          end
        end
      endcase
    end else if (phase_r == PH_READY && (kind_r != KIND_BOOL || bool_elem_end)) begin
      if (group_end) begin
        phase_nxt = PH_HEADER;
      end else if (!is_run_r) begin
        phase_nxt = PH_LIT;
      end
    end
  end

  // datapath and result
  always_comb begin
    is_run_nxt     = is_run_r;
    items_left_nxt = items_left_r;
    cur_nxt        = cur_r;
    delta_nxt      = delta_r;
    shift_nxt      = shift_r;
    bit_mask_nxt   = bit_mask_r;
    bits_byte_nxt  = bits_byte_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b0;
    if (in_op_r == OP_BYTE) begin
      if (phase_r == PH_READY) begin
        out_status_nxt = ST_REFUSED;
      end else begin
        unique case (phase_r)
          PH_DELTA: begin
            delta_nxt = in_byte_r;
            cur_nxt   = '0;
            shift_nxt = '0;
          end
          PH_BASE, PH_LIT: begin
            unique case (kind_r)
              KIND_BOOL: begin
                bits_byte_nxt = in_byte_r;
                bit_mask_nxt  = MaskFirst;
              end
              KIND_BYTE: cur_nxt = ValueWidth'(in_byte_r);
              default: begin
                if (shift_r < VarintLimit) begin
                  cur_nxt = cur_r | varint_bits;
                  if (!varint_done) begin
                    shift_nxt = shift_r + VarintStep;
                  end
                end
              end
            endcase
          end
          default: begin
            is_run_nxt     = !in_byte_r[ByteWidth-1];
            items_left_nxt = in_byte_r[ByteWidth-1] ? (8'd0 - in_byte_r)
                                                    : (in_byte_r + RunBias);
            cur_nxt        = '0;
            shift_nxt      = '0;
            delta_nxt      = '0;
          end
        endcase
      end
    end else if (phase_r != PH_READY) begin
      out_status_nxt = ST_EMPTY;
    end else begin
      if (kind_r == KIND_BOOL) begin
        out_value_nxt = ValueWidth'(|(bits_byte_r & bit_mask_r));
        bit_mask_nxt  = mask_shifted;
      end else begin
        out_value_nxt = cur_r;
        if (is_run_r) begin
          if (kind_r == KIND_UINT) begin
            cur_nxt = cur_r + delta_ext;
          end else if (kind_r == KIND_SINT) begin
            cur_nxt = (zz_sum << 1) ^ {ValueWidth{zz_sum[ValueWidth-1]}};
          end
        end
      end
      if (kind_r != KIND_BOOL || bool_elem_end) begin
        items_left_nxt = items_dec;
        out_last_nxt   = group_end;
        if (!group_end) begin
          if (!is_run_r) begin
            cur_nxt   = '0;
            shift_nxt = '0;
          end else if (kind_r == KIND_BOOL) begin
            bit_mask_nxt = MaskFirst;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= KIND_UINT;
      phase_r      <= PH_HEADER;
      is_run_r     <= 1'b0;
      items_left_r <= '0;
      cur_r        <= '0;
      delta_r      <= '0;
      shift_r      <= '0;
      bit_mask_r   <= '0;
      bits_byte_r  <= '0;
    end else if (cfg_wr_en) begin
      kind_r       <= kind_t'(cfg_wr_data);
      phase_r      <= PH_HEADER;
      is_run_r     <= 1'b0;
      items_left_r <= '0;
      cur_r        <= '0;
      delta_r      <= '0;
      shift_r      <= '0;
      bit_mask_r   <= '0;
      bits_byte_r  <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      is_run_r     <= is_run_nxt;
      items_left_r <= items_left_nxt;
      cur_r        <= cur_nxt;
      delta_r      <= delta_nxt;
      shift_r      <= shift_nxt;
      bit_mask_r   <= bit_mask_nxt;
      bits_byte_r  <= bits_byte_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= op_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && has_result) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_ready_has_items: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_READY |-> items_left_r != '0)
    else $error("value pending with empty group count");

  a_bool_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY && kind_r == KIND_BOOL) |-> bit_mask_r != '0)
    else $error("boolean value pending with no bit selected");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r <= ShiftMax)
    else $error("varint shift beyond limit");

  a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r != ST_OK) |-> (out_value_r == '0 && !out_last_r))
    else $error("non-valid result carries data");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !(fire && has_result))
    else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

/* tb/tb_columnar_rle_v1_stream_decoder.sv */
`timescale 1ns / 100ps
module tb_columnar_rle_v1_stream_decoder;
  import crle_pkg::*;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } stream_item_t;

  typedef struct {
    logic [63:0] val;
    status_t     status;
    logic        ends_group;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  stream_item_t item_q[$];
  decoded_t     value_q[$];
  int unsigned  mismatches = 0;
  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;

  kind_t phase_kind [1:12] = '{KIND_BOOL, KIND_SINT, KIND_BYTE, KIND_UINT,
                               KIND_SINT, KIND_BOOL, KIND_BYTE, KIND_UINT,
                               KIND_BOOL, KIND_SINT, KIND_BYTE, KIND_UINT};

  // decoder state mirror
  kind_t       dec_kind;
  phase_t      dec_phase;
  logic        dec_run;
  logic [7:0]  dec_left;
  logic [63:0] dec_val;
  logic [7:0]  dec_delta;
  logic [6:0]  dec_shift;
  logic [7:0]  dec_mask;
  logic [7:0]  dec_bits;

  columnar_rle_v1_stream_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_decoder();
    dec_phase = PH_HEADER;
    dec_run   = 1'b0;
    dec_left  = '0;
    dec_val   = '0;
    dec_delta = '0;
    dec_shift = '0;
    dec_mask  = '0;
    dec_bits  = '0;
  endfunction

  function automatic logic finish_element();
    dec_left = dec_left - 8'd1;
    if (dec_left == 8'd0) begin
      dec_phase = PH_HEADER;
      return 1'b1;
    end
    if (!dec_run) begin
      dec_phase = PH_LIT;
      dec_val   = '0;
      dec_shift = '0;
    end
    return 1'b0;
  endfunction

  // returns 1 when the transfer yields an output transfer
  function automatic logic decode_transfer(op_t op, logic [7:0] b, output decoded_t r);
    logic [63:0] step;
    logic [63:0] plain;
    r.val        = '0;
    r.status     = ST_OK;
    r.ends_group = 1'b0;
    step = {{56{dec_delta[7]}}, dec_delta};
    if (op == OP_BYTE) begin
      if (dec_phase == PH_READY) begin
        r.status = ST_REFUSED;
        return 1'b1;
      end
      case (dec_phase)
        PH_DELTA: begin
          dec_delta = b;
          dec_val   = '0;
          dec_shift = '0;
          dec_phase = PH_BASE;
        end
        PH_BASE, PH_LIT: begin
          if (dec_kind == KIND_BOOL) begin
            dec_bits  = b;
            dec_mask  = MaskFirst;
            dec_phase = PH_READY;
          end else if (dec_kind == KIND_BYTE) begin
            dec_val   = 64'(b);
            dec_phase = PH_READY;
          end else begin
            if (dec_shift < VarintLimit) dec_val = dec_val | (64'(b & DataBits) << dec_shift);
            if (!b[7]) dec_phase = PH_READY;
            else if (dec_shift < VarintLimit) dec_shift = dec_shift + VarintStep;
          end
        end
        default: begin
          if (b[7]) begin
            dec_run  = 1'b0;
            dec_left = 8'd0 - b;
          end else begin
            dec_run  = 1'b1;
            dec_left = b + RunBias;
          end
          dec_val   = '0;
          dec_shift = '0;
          dec_delta = '0;
          if (!dec_run) dec_phase = PH_LIT;
          else if (dec_kind == KIND_UINT || dec_kind == KIND_SINT) dec_phase = PH_DELTA;
          else dec_phase = PH_BASE;
        end
      endcase
      return 1'b0;
    end
    if (dec_phase != PH_READY) begin
      r.status = ST_EMPTY;
      return 1'b1;
    end
    if (dec_kind == KIND_BOOL) begin
      r.val    = {63'd0, |(dec_bits & dec_mask)};
      dec_mask = dec_mask >> 1;
      if (dec_mask == 8'd0) begin
        r.ends_group = finish_element();
        if (dec_phase == PH_READY) dec_mask = MaskFirst;
      end
    end else begin
      r.val = dec_val;
      if (dec_run) begin
        if (dec_kind == KIND_UINT) begin
          dec_val = dec_val + step;
        end else if (dec_kind == KIND_SINT) begin
          plain   = ((dec_val >> 1) ^ {64{dec_val[0]}}) + step;
          dec_val = (plain << 1) ^ {64{plain[63]}};
        end
      end
      r.ends_group = finish_element();
    end
    return 1'b1;
  endfunction

  // sender
  always @(posedge clk) begin : drive_input
    stream_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = item_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= it.op;
        in_tdata  <= it.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // output check and prediction
  always @(posedge clk) begin : check_output
    decoded_t want;
    decoded_t got;
    if (!rst_n) begin
      dec_kind = KIND_UINT;
      clear_decoder();
      value_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (value_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, got value %h status %0d last %0d",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = value_q.pop_front();
          if (out_tdata !== want.val) begin
            mismatches++;
            $display("%0t: value expected %h, got %h", $time, want.val, out_tdata);
          end
          if (out_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
          end
          if (out_tlast !== want.ends_group) begin
            mismatches++;
            $display("%0t: last expected %0d, got %0d", $time, want.ends_group, out_tlast);
          end
        end
      end
      if (cfg_wr_en) begin
        dec_kind = kind_t'(cfg_wr_data);
        clear_decoder();
      end
      if (in_tvalid && in_tready) begin
        if (decode_transfer(op_t'(in_tuser), in_tdata, got)) value_q.push_back(got);
      end
    end
  end

  task automatic push_item(op_t op, logic [7:0] data);
    stream_item_t it;
    it.op   = op;
    it.data = data;
    item_q.push_back(it);
  endtask

  // a pull while a value is pending; now and then a byte is refused first
  task automatic push_pull();
    if ($urandom_range(24) == 0) push_item(OP_BYTE, 8'($urandom));
    push_item(OP_PULL, 8'($urandom));
  endtask

  task automatic push_varint();
    int len;
    int r;
    int i;
    r = $urandom_range(99);
    if (r < 50) len = 1;
    else if (r < 80) len = $urandom_range(2, 3);
    else if (r < 95) len = $urandom_range(4, 9);
    else len = $urandom_range(10, 12);
    for (i = 0; i < len; i++)
      push_item(OP_BYTE, {(i != len - 1), 7'($urandom)});
  endtask

  // extreme: 0 random size, 1 longest run, 2 longest literal group
  task automatic gen_group(kind_t k, int extreme);
    bit run;
    int n;
    int per;
    int i;
    int j;
    per = (k == KIND_BOOL) ? 8 : 1;
    if (extreme != 0) begin
      run = (extreme == 1);
      n = run ? 130 : 128;
    end else begin
      run = 1'($urandom_range(1));
      if ($urandom_range(39) == 0) n = run ? 130 : 128;
      else n = run ? $urandom_range(3, 10) : $urandom_range(1, 8);
    end
    push_item(OP_BYTE, run ? 8'(n - 3) : 8'(256 - n));
    if (run) begin
      if (k == KIND_UINT || k == KIND_SINT) begin
        push_item(OP_BYTE, 8'($urandom));
        push_varint();
      end else begin
        push_item(OP_BYTE, 8'($urandom));
      end
      for (i = 0; i < n * per; i++) push_pull();
    end else begin
      for (i = 0; i < n; i++) begin
        if (k == KIND_UINT || k == KIND_SINT) push_varint();
        else push_item(OP_BYTE, 8'($urandom));
        for (j = 0; j < per; j++) push_pull();
      end
    end
    if ($urandom_range(24) == 0) push_item(OP_PULL, 8'($urandom));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || in_tvalid || value_q.size() != 0);
  endtask

  initial begin : stimulus
    int p;
    send_idle = 7;
    recv_idle = 75;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // unsigned kind out of reset
    push_item(OP_PULL, 8'hFF);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h80);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_BYTE, 8'h55);
    repeat (3) push_item(OP_PULL, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    repeat (11) push_item(OP_BYTE, 8'hFF);   // varint past 64 bits
    push_item(OP_BYTE, 8'h7F);
    push_item(OP_PULL, 8'h00);
    push_item(OP_PULL, 8'h00);
    wait_drained();
    for (p = 1; p <= 12; p++) begin
      if (p == 5) begin
        send_idle = 75;
        recv_idle = 7;
      end
      if (p == 9) begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (4) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_kind[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      if (p == 4) gen_group(phase_kind[p], 1);
      if (p == 7) gen_group(phase_kind[p], 2);
      while (item_q.size() < 80) gen_group(phase_kind[p], 0);
      // broken tail, cleared by the next kind write
      repeat (6) push_item(op_t'($urandom_range(1)), 8'($urandom));
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* columnar_rle_v1_stream_decoder.f */
sv/crle_pkg.sv
sv/columnar_rle_v1_stream_decoder.sv
tb/tb_columnar_rle_v1_stream_decoder.sv
